>>> hdl/assert_macros.svh
// assertion macros used by the receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> hdl/mbrx_pkg.sv
// types, constants and the crc byte update for the modbus rtu receiver
package mbrx_pkg;

	localparam int MAX_FRAME_BYTES = 256;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int HDR_LEN         = 6;
	localparam int HDR_IDX_W       = $clog2(HDR_LEN);
	localparam int ADDR_W          = 5;
	localparam int DATA_W          = 32;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// request opcodes
	localparam logic [1:0] FN_BYTE    = 2'd0;
	localparam logic [1:0] FN_TICK    = 2'd1;
	localparam logic [1:0] FN_RELEASE = 2'd2;
	localparam logic [1:0] FN_NOP     = 2'd3;

	// register indexes
	localparam logic [2:0] REG_GAP        = 3'd0;
	localparam logic [2:0] REG_FRAME_END  = 3'd1;
	localparam logic [2:0] REG_IDLE_START = 3'd2;
	localparam logic [2:0] REG_OWN_ADDR   = 3'd3;
	localparam logic [2:0] REG_ANY_ADDR   = 3'd4;

	// function codes with an implied quantity of one
	localparam logic [7:0] FC_WRITE_COIL = 8'd5;
	localparam logic [7:0] FC_WRITE_REG  = 8'd6;

	typedef struct packed {
		logic [15:0] gap_ticks;
		logic [15:0] frame_end_ticks;
		logic [15:0] idle_start_ticks;
		logic [7:0]  own_address;
		logic        accept_any_address;
	} cfg_t;

	typedef struct packed {
		logic [15:0]                 silence;
		logic                        timer;
		logic                        recv;
		logic                        gap;
		logic                        idle;
		logic                        comp;
		logic [CNT_W-1:0]            count;
		logic [HDR_LEN-1:0][7:0]     hdr;
		logic [15:0]                 crc;
	} state_t;

	typedef struct packed {
		logic        frame_ok;
		logic        frame_dropped;
		logic        gap_seen;
		logic        bus_idle;
		logic        holding;
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
		logic [15:0] start_address;
		logic [15:0] quantity;
		logic [CNT_W-1:0] frame_length;
	} result_t;

	// reflected crc-16, one byte, bit by bit
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/mbrx_regs.sv
// configuration register file behind the apb port
module mbrx_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbrx_pkg::ADDR_W-1:0] paddr,
	input  logic [mbrx_pkg::DATA_W-1:0] pwdata,
	output logic [mbrx_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output mbrx_pkg::cfg_t              cfg
);
	import mbrx_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ticks          <= 16'd15;
			cfg_q.frame_end_ticks    <= 16'd35;
			cfg_q.idle_start_ticks   <= 16'd35;
			cfg_q.own_address        <= 8'd0;
			cfg_q.accept_any_address <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GAP:        cfg_q.gap_ticks          <= pwdata[15:0];
				REG_FRAME_END:  cfg_q.frame_end_ticks    <= pwdata[15:0];
				REG_IDLE_START: cfg_q.idle_start_ticks   <= pwdata[15:0];
				REG_OWN_ADDR:   cfg_q.own_address        <= pwdata[7:0];
				REG_ANY_ADDR:   cfg_q.accept_any_address <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_GAP:        prdata = {16'd0, cfg_q.gap_ticks};
			REG_FRAME_END:  prdata = {16'd0, cfg_q.frame_end_ticks};
			REG_IDLE_START: prdata = {16'd0, cfg_q.idle_start_ticks};
			REG_OWN_ADDR:   prdata = {24'd0, cfg_q.own_address};
			REG_ANY_ADDR:   prdata = {31'd0, cfg_q.accept_any_address};
			default:        prdata = '0;
		endcase
	end

endmodule

>>> hdl/modbus_rtu_frame_receiver.sv
// modbus rtu frame receiver: the result of each accepted request is registered in the output buffer
// throughput 1 request per cycle while in_stall is low; byte, tick and release are each handled in one pass
// of the state update logic, the crc byte update unrolled in that same pass
// a two-entry output buffer keeps requests flowing while one result waits
// async reset loads the register defaults, clears the flags but sets the timer, clears the header, crc to all ones
module modbus_rtu_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  func,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        frame_ok,
	output logic                        frame_dropped,
	output logic                        gap_seen,
	output logic                        bus_idle,
	output logic                        holding,
	output logic [7:0]                  slave_address,
	output logic [7:0]                  function_code,
	output logic [15:0]                 start_address,
	output logic [15:0]                 quantity,
	output logic [8:0]                  frame_length,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbrx_pkg::ADDR_W-1:0] paddr,
	input  logic [mbrx_pkg::DATA_W-1:0] pwdata,
	output logic [mbrx_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import mbrx_pkg::*;
	`include "assert_macros.svh"

	cfg_t    cfg;
	state_t  st_q;
	state_t  st_nxt;
	result_t res;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    in_take;
	logic    out_take;
	logic    ok;
	logic    dropped;
	logic    addr_ok;
	logic [15:0] sil_inc;

	mbrx_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = skid_valid_q;
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign sil_inc  = st_q.silence + 16'd1;
	assign addr_ok  = cfg.accept_any_address || (st_q.hdr[0] == cfg.own_address);

	// frame state update for one request
	always_comb begin
		st_nxt  = st_q;
		ok      = 1'b0;
		dropped = 1'b0;
		unique case (func)
			FN_BYTE: begin
				st_nxt.silence = 16'd0;
				if (!st_q.comp && st_q.recv && !st_q.idle) begin
					if (st_q.count >= CNT_W'(MAX_FRAME_BYTES)) begin
						// overflow drops the frame
						st_nxt.timer = 1'b1;
						st_nxt.recv  = 1'b0;
						st_nxt.gap   = 1'b0;
						st_nxt.idle  = 1'b0;
						st_nxt.comp  = 1'b0;
						dropped      = 1'b1;
					end else begin
						if (st_q.count < CNT_W'(HDR_LEN)) begin
							st_nxt.hdr[st_q.count[HDR_IDX_W-1:0]] = rx_byte;
						end
						st_nxt.crc   = crc_update(st_q.crc, rx_byte);
						st_nxt.count = st_q.count + CNT_W'(1);
					end
				end else if (!st_q.comp && !st_q.recv && st_q.idle) begin
					// first byte of a new frame
					st_nxt.hdr    = '0;
					st_nxt.hdr[0] = rx_byte;
					st_nxt.crc    = crc_update(CRC_INIT, rx_byte);
					st_nxt.count  = CNT_W'(1);
					st_nxt.recv   = 1'b1;
					st_nxt.timer  = 1'b1;
					st_nxt.gap    = 1'b0;
					st_nxt.idle   = 1'b0;
				end
			end
			FN_TICK: begin
				if (st_q.timer) begin
					st_nxt.silence = sil_inc;
					if (st_q.recv) begin
						priority if (sil_inc == cfg.gap_ticks) begin
							st_nxt.gap = 1'b1;
						end else if (sil_inc == cfg.frame_end_ticks) begin
							st_nxt.recv = 1'b0;
							st_nxt.gap  = 1'b0;
							st_nxt.idle = 1'b0;
							if (st_q.count >= CNT_W'(4) && addr_ok && st_q.crc == 16'd0) begin
								st_nxt.comp  = 1'b1;
								st_nxt.timer = 1'b0;
								ok           = 1'b1;
							end else begin
								st_nxt.comp    = 1'b0;
								st_nxt.timer   = 1'b1;
								st_nxt.silence = 16'd0;
								dropped        = 1'b1;
							end
						end else begin
						end
					end else if (sil_inc == cfg.idle_start_ticks) begin
						st_nxt.idle = 1'b1;
					end
				end
			end
			FN_RELEASE: begin
				if (st_q.comp) begin
					st_nxt.timer   = 1'b1;
					st_nxt.recv    = 1'b0;
					st_nxt.gap     = 1'b0;
					st_nxt.idle    = 1'b0;
					st_nxt.comp    = 1'b0;
					st_nxt.silence = 16'd0;
				end
			end
			FN_NOP: begin
			end
		endcase
	end

	// result fields from the updated state
	always_comb begin
		res.frame_ok      = ok;
		res.frame_dropped = dropped;
		res.gap_seen      = st_nxt.gap;
		res.bus_idle      = st_nxt.idle;
		res.holding       = st_nxt.comp;
		res.frame_length  = st_nxt.count;
		if (st_nxt.comp) begin
			res.slave_address = st_nxt.hdr[0];
			res.function_code = st_nxt.hdr[1];
			res.start_address = {st_nxt.hdr[2], st_nxt.hdr[3]};
			if (st_nxt.hdr[1] == FC_WRITE_COIL || st_nxt.hdr[1] == FC_WRITE_REG) begin
				res.quantity = 16'd1;
			end else begin
				res.quantity = {st_nxt.hdr[4], st_nxt.hdr[5]};
			end
		end else begin
			res.slave_address = 8'd0;
			res.function_code = 8'd0;
			res.start_address = 16'd0;
			res.quantity      = 16'd0;
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.silence <= 16'd0;
			st_q.timer   <= 1'b1;
			st_q.recv    <= 1'b0;
			st_q.gap     <= 1'b0;
			st_q.idle    <= 1'b0;
			st_q.comp    <= 1'b0;
			st_q.count   <= '0;
			st_q.hdr     <= '0;
			st_q.crc     <= CRC_INIT;
		end else if (in_take) begin
			st_q <= st_nxt;
		end
	end

	// output buffer valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				if (out_valid_q && !out_take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (out_take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_ok      = out_q.frame_ok;
	assign frame_dropped = out_q.frame_dropped;
	assign gap_seen      = out_q.gap_seen;
	assign bus_idle      = out_q.bus_idle;
	assign holding       = out_q.holding;
	assign slave_address = out_q.slave_address;
	assign function_code = out_q.function_code;
	assign start_address = out_q.start_address;
	assign quantity      = out_q.quantity;
	assign frame_length  = out_q.frame_length;

	// checks
	`ASSERT_NEVER(a_hold_and_recv, clk, arst_n, st_q.comp && st_q.recv)
	`ASSERT_HOLDS(a_hold_stops_timer, clk, arst_n, st_q.comp |-> !st_q.timer)
	`ASSERT_NEVER(a_skid_without_main, clk, arst_n, skid_valid_q && !out_valid_q)
	`ASSERT_NEVER(a_ok_and_drop, clk, arst_n, out_valid_q && out_q.frame_ok && out_q.frame_dropped)
	`ASSERT_NEVER(a_count_limit, clk, arst_n, st_q.count > CNT_W'(MAX_FRAME_BYTES))

endmodule

>>> tb/sv/modbus_rtu_frame_receiver_checker.sv
// request and result monitor with a frame receiver predictor and field checks
module modbus_rtu_frame_receiver_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [1:0]                  func,
	input  logic [7:0]                  rx_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        frame_ok,
	input  logic                        frame_dropped,
	input  logic                        gap_seen,
	input  logic                        bus_idle,
	input  logic                        holding,
	input  logic [7:0]                  slave_address,
	input  logic [7:0]                  function_code,
	input  logic [15:0]                 start_address,
	input  logic [15:0]                 quantity,
	input  logic [8:0]                  frame_length,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [mbrx_pkg::ADDR_W-1:0] paddr,
	input  logic [mbrx_pkg::DATA_W-1:0] pwdata,
	output int                          errors,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import mbrx_pkg::*;

	// predictor copy of the configuration and receiver state
	cfg_t        cfg;
	logic [15:0] silence;
	logic        timer_on;
	logic        receiving;
	logic        gap_q;
	logic        idle_q;
	logic        hold_q;
	logic [8:0]  byte_cnt;
	logic [7:0]  hdr [HDR_LEN];
	logic [15:0] crc_acc;

	// frame status snapshots still owed by the block, oldest first
	result_t     awaited_status [$];
	result_t     want;

	// reflected crc-16 over one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// abandon the frame and listen for silence again
	function automatic void drop_to_listen();
		timer_on  = 1'b1;
		receiving = 1'b0;
		gap_q     = 1'b0;
		idle_q    = 1'b0;
		hold_q    = 1'b0;
		silence   = 16'd0;
	endfunction

	// apply one request to the predicted state and queue the status it must produce
	task automatic advance_receiver(input logic [1:0] f, input logic [7:0] b);
		result_t r;
		logic    ok;
		logic    dropped;
		logic    addr_match;
		ok      = 1'b0;
		dropped = 1'b0;
		case (f)
			FN_BYTE: begin
				silence = 16'd0;
				if (!hold_q && receiving && !idle_q) begin
					if (byte_cnt >= MAX_FRAME_BYTES) begin
						drop_to_listen();
						dropped = 1'b1;
					end else begin
						if (byte_cnt < HDR_LEN) begin
							hdr[byte_cnt[2:0]] = b;
						end
						crc_acc  = crc16_byte(crc_acc, b);
						byte_cnt = byte_cnt + 9'd1;
					end
				end else if (!hold_q && !receiving && idle_q) begin
					foreach (hdr[i]) begin
						hdr[i] = 8'h00;
					end
					hdr[0]    = b;
					crc_acc   = crc16_byte(CRC_INIT, b);
					byte_cnt  = 9'd1;
					receiving = 1'b1;
					timer_on  = 1'b1;
					gap_q     = 1'b0;
					idle_q    = 1'b0;
				end
			end
			FN_TICK: begin
				if (timer_on) begin
					silence = silence + 16'd1;
					if (receiving) begin
						// gap test has priority over the frame end test
						if (silence == cfg.gap_ticks) begin
							gap_q = 1'b1;
						end else if (silence == cfg.frame_end_ticks) begin
							addr_match = cfg.accept_any_address ||
								(hdr[0] == cfg.own_address);
							if (byte_cnt >= 9'd4 && addr_match && crc_acc == 16'h0000) begin
								hold_q    = 1'b1;
								timer_on  = 1'b0;
								receiving = 1'b0;
								gap_q     = 1'b0;
								idle_q    = 1'b0;
								ok        = 1'b1;
							end else begin
								drop_to_listen();
								dropped = 1'b1;
							end
						end
					end else if (silence == cfg.idle_start_ticks) begin
						idle_q = 1'b1;
					end
				end
			end
			FN_RELEASE: begin
				if (hold_q) begin
					drop_to_listen();
				end
			end
			default: begin
			end
		endcase

		r.frame_ok      = ok;
		r.frame_dropped = dropped;
		r.gap_seen      = gap_q;
		r.bus_idle      = idle_q;
		r.holding       = hold_q;
		if (hold_q) begin
			r.slave_address = hdr[0];
			r.function_code = hdr[1];
			r.start_address = {hdr[2], hdr[3]};
			if (hdr[1] == FC_WRITE_COIL || hdr[1] == FC_WRITE_REG) begin
				r.quantity = 16'd1;
			end else begin
				r.quantity = {hdr[4], hdr[5]};
			end
		end else begin
			r.slave_address = 8'h00;
			r.function_code = 8'h00;
			r.start_address = 16'h0000;
			r.quantity      = 16'h0000;
		end
		r.frame_length = byte_cnt;
		awaited_status.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	// sample both channels and the register port at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.gap_ticks          = 16'd15;
			cfg.frame_end_ticks    = 16'd35;
			cfg.idle_start_ticks   = 16'd35;
			cfg.own_address        = 8'h00;
			cfg.accept_any_address = 1'b0;
			silence   = 16'd0;
			timer_on  = 1'b1;
			receiving = 1'b0;
			gap_q     = 1'b0;
			idle_q    = 1'b0;
			hold_q    = 1'b0;
			byte_cnt  = 9'd0;
			foreach (hdr[i]) begin
				hdr[i] = 8'h00;
			end
			crc_acc   = CRC_INIT;
			awaited_status.delete();
			errors      = 0;
			outstanding = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_GAP:        cfg.gap_ticks          = pwdata[15:0];
					REG_FRAME_END:  cfg.frame_end_ticks    = pwdata[15:0];
					REG_IDLE_START: cfg.idle_start_ticks   = pwdata[15:0];
					REG_OWN_ADDR:   cfg.own_address        = pwdata[7:0];
					REG_ANY_ADDR:   cfg.accept_any_address = pwdata[0];
					default: begin
					end
				endcase
			end

			// accepted request
			if (in_valid && !in_stall) begin
				advance_receiver(func, rx_byte);
			end

			// accepted result against the oldest expectation
			if (out_valid && !out_stall) begin
				if (awaited_status.size() == 0) begin
					$error("result with no request waiting for it");
					errors++;
				end else begin
					want = awaited_status.pop_front();
					compare_field("frame_ok", 16'(want.frame_ok), 16'(frame_ok));
					compare_field("frame_dropped", 16'(want.frame_dropped),
						16'(frame_dropped));
					compare_field("gap_seen", 16'(want.gap_seen), 16'(gap_seen));
					compare_field("bus_idle", 16'(want.bus_idle), 16'(bus_idle));
					compare_field("holding", 16'(want.holding), 16'(holding));
					compare_field("slave_address", 16'(want.slave_address),
						16'(slave_address));
					compare_field("function_code", 16'(want.function_code),
						16'(function_code));
					compare_field("start_address", want.start_address, start_address);
					compare_field("quantity", want.quantity, quantity);
					compare_field("frame_length", 16'(want.frame_length),
						16'(frame_length));
				end
			end
			outstanding = awaited_status.size();
		end
	end

endmodule

>>> tb/sv/modbus_rtu_frame_receiver_tb.sv
// top of the frame receiver testbench: clock, reset, stimulus and verdict
module modbus_rtu_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mbrx_pkg::*;

	// pressure applied inside a phase
	localparam int PRESS_NONE  = 0;
	localparam int PRESS_PAUSE = 1;
	localparam int PRESS_HOLD  = 2;

	localparam int HOLD_CYCLES = 60;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          func;
	logic [7:0]          rx_byte;
	logic                out_valid;
	logic                out_stall;
	logic                frame_ok;
	logic                frame_dropped;
	logic                gap_seen;
	logic                bus_idle;
	logic                holding;
	logic [7:0]          slave_address;
	logic [7:0]          function_code;
	logic [15:0]         start_address;
	logic [15:0]         quantity;
	logic [8:0]          frame_length;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	int                  errors;
	int                  outstanding;

	// stimulus knobs
	int                  send_idle_pct = 0;
	int                  stall_pct     = 0;
	int                  tick_cap      = 100;
	logic                long_hold     = 1'b0;
	int                  requests_sent = 0;

	// timing currently programmed, used to shape frames
	int                  set_gap;
	int                  set_fe;
	int                  set_idle;
	logic [7:0]          set_own;

	logic [7:0]          frame_buf [$];

	modbus_rtu_frame_receiver dut (.*);

	modbus_rtu_frame_receiver_checker chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	initial begin
		#40ms;
		$display("modbus_rtu_frame_receiver_tb failed");
		$finish;
	end

	// result side: random stall with an occasional long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// offer one request and wait until it is taken
	task automatic send_item(input logic [1:0] f, input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func     <= f;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic send_ticks(input int n);
		int k;
		k = (n < tick_cap) ? n : tick_cap;
		repeat (k) send_item(FN_TICK, rand_byte());
	endtask

	// append the crc, low byte first
	task automatic seal_frame();
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frame_buf[i]) begin
			c = c ^ {8'h00, frame_buf[i]};
			repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		frame_buf.push_back(c[7:0]);
		frame_buf.push_back(c[15:8]);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input int gap, input int fe, input int idle,
		input logic [7:0] own, input logic any);
		reg_write(REG_GAP, gap);
		reg_write(REG_FRAME_END, fe);
		reg_write(REG_IDLE_START, idle);
		reg_write(REG_OWN_ADDR, {24'h0, own});
		reg_write(REG_ANY_ADDR, {31'h0, any});
		set_gap  = gap;
		set_fe   = fe;
		set_idle = idle;
		set_own  = own;
	endtask

	// hold off new requests until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// silence, one frame, end silence, mostly a release
	task automatic run_sequence();
		int lead;
		int pick;
		int n;
		int mid_max;
		int idx;
		logic [7:0] fc;

		// lead-in, sometimes too short for the bus to go idle
		if ($urandom_range(9) == 0) begin
			lead = $urandom_range(0, set_idle - 1);
		end else begin
			lead = set_idle + $urandom_range(0, 2);
		end
		send_ticks(lead);

		frame_buf.delete();
		pick = $urandom_range(99);
		if (pick < 72) begin
			// well-formed frame, the upper part of the range gets a flipped bit
			case ($urandom_range(4))
				0: fc = FC_WRITE_COIL;
				1: fc = FC_WRITE_REG;
				2: fc = 8'd3;
				3: fc = 8'd16;
				default: fc = rand_byte();
			endcase
			frame_buf.push_back(($urandom_range(3) != 0) ? set_own : rand_byte());
			frame_buf.push_back(fc);
			repeat ($urandom_range(0, 6)) frame_buf.push_back(rand_byte());
			seal_frame();
			if (pick >= 60) begin
				idx = $urandom_range(0, frame_buf.size() - 1);
				frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
			end
		end else if (pick < 82) begin
			// short frame with a good crc
			if ($urandom_range(1) == 1) begin
				frame_buf.push_back(set_own);
			end
			seal_frame();
		end else if (pick < 86) begin
			// near the length limit, past it for the two longest
			frame_buf.push_back(set_own);
			repeat ($urandom_range(252, 255)) frame_buf.push_back(rand_byte());
			seal_frame();
		end else begin
			repeat ($urandom_range(1, 12)) frame_buf.push_back(rand_byte());
		end

		// silence inside the frame stays below the frame end
		mid_max = (set_gap < set_fe) ? set_gap : set_fe - 1;
		foreach (frame_buf[i]) begin
			send_item(FN_BYTE, frame_buf[i]);
			if (mid_max > 0 && $urandom_range(11) == 0) begin
				send_ticks($urandom_range(1, mid_max));
			end
		end

		send_ticks(set_fe + $urandom_range(0, 1));

		// stray requests while the frame is held, then release
		if ($urandom_range(9) < 8) begin
			if ($urandom_range(2) == 0) begin
				repeat ($urandom_range(1, 3)) send_item(2'($urandom_range(3)), rand_byte());
			end
			send_item(FN_RELEASE, rand_byte());
		end
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(3)), rand_byte());
		end
	endtask

	// leave the receiver out of any frame before the next setting
	task automatic settle();
		send_item(FN_RELEASE, rand_byte());
		if (set_gap == set_fe || set_fe > tick_cap) begin
			// only an overflow ends a frame here
			repeat (MAX_FRAME_BYTES + 2) send_item(FN_BYTE, rand_byte());
		end else begin
			send_item(FN_BYTE, rand_byte());
			send_ticks(set_fe);
			send_item(FN_RELEASE, rand_byte());
		end
	endtask

	task automatic run_phase(input int gap, input int fe, input int idle,
		input logic [7:0] own, input logic any, input int sidle, input int stall,
		input int budget, input int cap, input int pressure);
		int   first;
		logic pressed;
		drain();
		configure(gap, fe, idle, own, any);
		send_idle_pct = sidle;
		stall_pct     = stall;
		tick_cap      = cap;
		first         = requests_sent;
		pressed       = 1'b0;
		while (requests_sent - first < budget) begin
			if (!pressed && requests_sent - first > budget / 3) begin
				pressed = 1'b1;
				if (pressure == PRESS_PAUSE) begin
					drain();
				end else if (pressure == PRESS_HOLD) begin
					long_hold = 1'b1;
				end
			end
			run_sequence();
		end
		settle();
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		func     = FN_NOP;
		rx_byte  = 8'h00;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ignored requests, an accepted write-coil frame, a short frame
		configure(2, 3, 2, 8'h11, 1'b0);
		send_item(FN_NOP, 8'hFF);
		send_item(FN_RELEASE, 8'h00);
		send_item(FN_BYTE, 8'h00);
		send_ticks(3);
		frame_buf = {8'h11, 8'h05, 8'h00, 8'h13, 8'hFF, 8'h00};
		seal_frame();
		foreach (frame_buf[i]) begin
			send_item(FN_BYTE, frame_buf[i]);
		end
		send_ticks(3);
		send_item(FN_BYTE, 8'hAA);
		send_item(FN_TICK, 8'h55);
		send_item(FN_RELEASE, 8'h00);
		send_ticks(2);
		send_item(FN_BYTE, 8'hFF);
		send_ticks(3);

		// random phases over several settings and idling patterns
		run_phase(3, 1, 1, 8'h00, 1'b1, 0, 0, 120, 100, PRESS_NONE);
		run_phase(3, 5, 4, 8'hFF, 1'b0, 65, 0, 120, 100, PRESS_PAUSE);
		run_phase(1, 1, 1, 8'hA5, 1'b0, 0, 65, 200, 100, PRESS_NONE);
		run_phase(15, 35, 35, 8'h00, 1'b0, 23, 23, 120, 100, PRESS_NONE);
		run_phase(2, 4, 3, 8'h3C, 1'b1, 0, 65, 120, 100, PRESS_HOLD);
		run_phase(65535, 65535, 65535, 8'h5A, 1'b1, 0, 0, 40, 100, PRESS_NONE);

		in_valid <= 1'b0;
		for (int w = 0; w < 20000 && outstanding != 0; w++) @(negedge clk);
		repeat (4) @(negedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("modbus_rtu_frame_receiver_tb passed");
		end else begin
			$display("modbus_rtu_frame_receiver_tb failed");
		end
		$finish;
	end

endmodule
